// ===== src/tec_pkg.sv =====
`default_nettype none
package tec_pkg;

  localparam int TabSize = 8;
  localparam int MaxRows = 128;
  localparam int MaxCols = 256;

  typedef enum logic [2:0] {
    CMD_DRAW   = 3'd0,
    CMD_MOVE   = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_SCROLL = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_BELL   = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ROWS    = 3'd0,
    REG_COLS    = 3'd1,
    REG_TAB     = 3'd2,
    REG_CURSOR  = 3'd3,
    REG_BELL    = 3'd4
  } reg_idx_t;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [7:0] K_ESC = 8'h1B;

  typedef struct packed {
    logic [2:0] cmd;
    logic [6:0] row;
    logic [7:0] col;
    logic [7:0] row_span;
    logic [8:0] col_span;
    logic [6:0] glyph;
    logic       inverse;
    logic [1:0] scroll_dir;
    logic [2:0] mode_flags;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] rows;
    logic [8:0] cols;
    logic [7:0] tab_limit;
    logic       cursor_visible;
    logic       bell_enabled;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/terminal_escape_cursor_engine_unit.sv =====
// Terminal escape and cursor engine.
// Input channel: push a byte on in_byte with in_push while in_full is low.
// Result channel: while out_empty is low the oldest command word sits on the
// out_ ports; out_pop takes it. Each byte gives zero to ten words, the last
// one flagged by out_last. A byte that gives no word only updates state.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high; write only while the block is idle.
// The first word of a byte passes the byte register and then the result
// register before it reaches the queue. The interpreter issues one word per
// cycle while the queue is not nearly full; a new byte is taken in the cycle
// its last word issues.
// A four-entry result queue decouples the interpreter from the receiver; when
// the receiver stalls the interpreter pauses once the queue is nearly full.
// Reset (synchronous, rst_n low) clears cursor, parser state, attributes,
// queue and restores the register defaults 24 rows, 80 columns, tab limit 72,
// cursor and bell enabled.
`default_nettype none
module terminal_escape_cursor_engine_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_byte,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [2:0]      out_cmd,
  output logic [6:0]      out_row,
  output logic [7:0]      out_col,
  output logic [7:0]      out_row_span,
  output logic [8:0]      out_col_span,
  output logic [6:0]      out_glyph,
  output logic            out_inverse,
  output logic [1:0]      out_scroll_dir,
  output logic [2:0]      out_mode_flags,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [8:0] cfg_data
);
  import tec_pkg::*;

  cfg_t cfg_r;
  logic res_valid, almost_full, qempty, pop;
  res_t res_data, q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{rows: 8'd24, cols: 9'd80, tab_limit: 8'd72, cursor_visible: 1'b1,
                 bell_enabled: 1'b1};
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ROWS:   cfg_r.rows           <= cfg_data[7:0];
        REG_COLS:   cfg_r.cols           <= cfg_data;
        REG_TAB:    cfg_r.tab_limit      <= cfg_data[7:0];
        REG_CURSOR: cfg_r.cursor_visible <= cfg_data[0];
        REG_BELL:   cfg_r.bell_enabled   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_push   (in_push),
    .in_data   (in_byte),
    .in_full   (in_full),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_stall (almost_full)
  );

  assign pop = out_pop && !qempty;

  tec_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (res_valid),
    .wr_data     (res_data),
    .almost_full (almost_full),
    .empty       (qempty),
    .rd_en       (pop),
    .rd_data     (q_data)
  );

  assign out_empty      = qempty;
  assign out_cmd        = q_data.cmd;
  assign out_row        = q_data.row;
  assign out_col        = q_data.col;
  assign out_row_span   = q_data.row_span;
  assign out_col_span   = q_data.col_span;
  assign out_glyph      = q_data.glyph;
  assign out_inverse    = q_data.inverse;
  assign out_scroll_dir = q_data.scroll_dir;
  assign out_mode_flags = q_data.mode_flags;
  assign out_last       = q_data.last;
endmodule
`default_nettype wire

// ===== src/tec_queue.sv =====
`default_nettype none
module tec_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire tec_pkg::res_t wr_data,
  output logic               almost_full,
  output logic               empty,
  input  wire logic          rd_en,
  output tec_pkg::res_t      rd_data
);
  import tec_pkg::*;

  res_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, wr_en} - {2'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assign rd_data     = mem_r[rp_r];
  assign empty       = (cnt_r == 3'd0);
  assign almost_full = (cnt_r >= 3'd3);
endmodule
`default_nettype wire

// ===== src/tec_core.sv =====
`default_nettype none
module tec_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tec_pkg::cfg_t cfg,
  input  wire logic          in_push,
  input  wire logic [7:0]    in_data,
  output logic               in_full,
  output logic               res_valid,
  output tec_pkg::res_t      res_data,
  input  wire logic          res_stall
);
  import tec_pkg::*;

  // Front register holds one byte while its command list is produced, one word per cycle unless the queue stalls.
  logic       busy_r, busy_nxt;
  logic [7:0] byte_r;
  logic [3:0] step_r, step_nxt;

  logic [7:0] cursor_col_r, cursor_col_nxt;
  logic [6:0] cursor_row_r, cursor_row_nxt;
  logic [7:0] escape_char_r, escape_char_nxt;
  logic [1:0] digit_count_r, digit_count_nxt;
  logic [9:0] addr_accum_r, addr_accum_nxt;
  logic [7:0] held_char_r, held_char_nxt;
  logic [2:0] attr_bits_r, attr_bits_nxt;
  logic       insert_mode_r, insert_mode_nxt;

  logic [7:0] nrows;
  logic [8:0] ncols;
  logic [6:0] crow;
  logic [7:0] ccol;

  res_t       list [12];
  logic [3:0] nres;
  logic       pend_r;
  res_t       pend_data_r;

  always_comb begin
    nrows = (cfg.rows == 8'd0) ? 8'd1 : ((cfg.rows > 8'(MaxRows)) ? 8'(MaxRows) : cfg.rows);
    ncols = (cfg.cols == 9'd0) ? 9'd1 : ((cfg.cols > 9'(MaxCols)) ? 9'(MaxCols) : cfg.cols);
    crow  = ({1'b0, cursor_row_r} > nrows - 8'd1) ? 7'(nrows - 8'd1) : cursor_row_r;
    ccol  = ({1'b0, cursor_col_r} > ncols - 9'd1) ? 8'(ncols - 9'd1) : cursor_col_r;
  end

  // Whole-byte interpretation; the command list is consumed over cycles.
  always_comb begin
    logic [7:0] e, c, pc;
    logic       plain;
    logic [7:0] rm1;
    logic [8:0] cm1;
    logic [8:0] tn;
    logic [13:0] acc;
    logic       wrap_req, down_req, dl_inv;
    int         k;

    cursor_col_nxt  = ccol;
    cursor_row_nxt  = crow;
    escape_char_nxt = escape_char_r;
    digit_count_nxt = digit_count_r;
    addr_accum_nxt  = addr_accum_r;
    held_char_nxt   = held_char_r;
    attr_bits_nxt   = attr_bits_r;
    insert_mode_nxt = insert_mode_r;
    for (int i = 0; i < 12; i++) list[i] = '0;
    k        = 0;
    c        = byte_r;
    e        = escape_char_r;
    plain    = 1'b0;
    rm1      = nrows - 8'd1;
    cm1      = ncols - 9'd1;
    tn       = '0;
    acc      = '0;
    wrap_req = 1'b0;
    down_req = 1'b0;
    dl_inv   = 1'b0;
    pc       = {1'b0, c[6:0]};

    if (e == 8'd0) plain = 1'b1;
    else begin
      if (e == K_ESC) begin
        escape_char_nxt = c;
        if (c == K_ESC) plain = 1'b1;
        else begin
          digit_count_nxt = 2'd0;
          e = c;
        end
      end
      if (!plain) begin
        escape_char_nxt = 8'd0;
        case (e)
          "&": begin
            if (digit_count_nxt != 2'd0) begin
              escape_char_nxt = c;
              digit_count_nxt = 2'd0;
            end else begin
              digit_count_nxt = 2'd1;
              escape_char_nxt = e;
            end
          end
          "a": begin
            if (c == "Y" || c == "y") begin
              cursor_row_nxt = ({6'd0, addr_accum_r} < {2'b0, rm1}) ?
                               7'(addr_accum_r) : 7'(rm1);
              addr_accum_nxt = '0;
              if (c == "y") begin
                digit_count_nxt = 2'd0;
                escape_char_nxt = e;
              end else begin
                if (cfg.cursor_visible) begin
                  list[k] = '{cmd: CMD_MOVE, row: cursor_row_nxt, col: cursor_col_nxt,
                              default: '0};
                  k++;
                end
                attr_bits_nxt[0] = 1'b0;
              end
            end else if (c == "C") begin
              cursor_col_nxt = ({1'b0, addr_accum_r} < {1'b0, cm1}) ?
                               8'(addr_accum_r) : 8'(cm1);
              addr_accum_nxt = '0;
              if (cfg.cursor_visible) begin
                list[k] = '{cmd: CMD_MOVE, row: cursor_row_nxt, col: cursor_col_nxt,
                            default: '0};
                k++;
              end
              attr_bits_nxt[0] = 1'b0;
            end else if (c >= "0" && c <= "9" && digit_count_nxt < 2'd3) begin
              acc = {4'd0, addr_accum_r} * 14'd10 + 14'(c - "0");
              addr_accum_nxt  = acc[9:0];
              digit_count_nxt = digit_count_nxt + 2'd1;
              escape_char_nxt = e;
            end else begin
              addr_accum_nxt = '0;
            end
          end
          "d": begin
            if (c == "B") attr_bits_nxt[0] = 1'b1;
            else if (c == "D") attr_bits_nxt[1] = 1'b1;
            else if (c == "@") attr_bits_nxt[1:0] = 2'b00;
          end
          "s": begin
            if (digit_count_nxt == 2'd0) begin
              held_char_nxt   = c;
              digit_count_nxt = 2'd1;
              escape_char_nxt = e;
            end else if (digit_count_nxt == 2'd1) begin
              if (c == "A") begin
                if (held_char_r == "0") attr_bits_nxt[2] = 1'b0;
                else if (held_char_r == "1") attr_bits_nxt[2] = 1'b1;
              end
              held_char_nxt = 8'd0;
            end
          end
          "i": begin
            cursor_col_nxt = (ccol > 8'(TabSize)) ? (ccol % 8'(TabSize)) : 8'd0;
            if (cfg.cursor_visible) begin
              list[k] = '{cmd: CMD_MOVE, row: crow, col: cursor_col_nxt, default: '0};
              k++;
            end
          end
          "K": begin
            list[k] = '{cmd: CMD_CLEAR, row: crow, col: ccol, row_span: 8'd1,
                        col_span: ncols - {1'b0, ccol}, default: '0};
            k++;
            if (cfg.cursor_visible) begin
              list[k] = '{cmd: CMD_CURSOR, row: crow, col: ccol, default: '0};
              k++;
            end
          end
          "J": begin
            list[k] = '{cmd: CMD_CLEAR, row: crow, col: 8'd0,
                        row_span: nrows - {1'b0, crow}, col_span: ncols, default: '0};
            k++;
            if (cfg.cursor_visible) begin
              list[k] = '{cmd: CMD_CURSOR, row: crow, col: ccol, default: '0};
              k++;
            end
          end
          "B": begin
            down_req = 1'b1;
            dl_inv   = 1'b1;
          end
          "C": wrap_req = 1'b1;
          "A": begin
            if (crow > 7'd0) begin
              cursor_row_nxt = crow - 7'd1;
              if (cfg.cursor_visible) begin
                list[k] = '{cmd: CMD_MOVE, row: cursor_row_nxt, col: ccol, default: '0};
                k++;
              end
            end
            attr_bits_nxt[0] = 1'b0;
          end
          "P": begin
            if ({1'b0, ccol} < cm1) begin
              if (cfg.cursor_visible) begin
                list[k] = '{cmd: CMD_ERASE, row: crow, col: ccol, default: '0};
                k++;
              end
              list[k] = '{cmd: CMD_SCROLL, row: crow, col: ccol + 8'd1, row_span: 8'd1,
                          col_span: cm1 - {1'b0, ccol}, scroll_dir: DIR_LEFT,
                          default: '0};
              k++;
            end
            list[k] = '{cmd: CMD_DRAW, row: crow, col: 8'(cm1), glyph: 7'h20, default: '0};
            k++;
            if (cfg.cursor_visible) begin
              list[k] = '{cmd: CMD_CURSOR, row: crow, col: ccol, default: '0};
              k++;
            end
          end
          "M", "L": begin
            if ({1'b0, crow} < rm1) begin
              if (cfg.cursor_visible) begin
                list[k] = '{cmd: CMD_ERASE, row: crow, col: ccol, default: '0};
                k++;
              end
              list[k] = '{cmd: CMD_SCROLL, row: (e == "M") ? crow + 7'd1 : crow, col: 8'd0,
                          row_span: rm1 - {1'b0, crow}, col_span: ncols,
                          scroll_dir: (e == "M") ? DIR_UP : DIR_DOWN, default: '0};
              k++;
            end
            list[k] = '{cmd: CMD_CLEAR, row: (e == "M") ? 7'(rm1) : crow, col: 8'd0,
                        row_span: 8'd1, col_span: ncols, default: '0};
            k++;
            if (cfg.cursor_visible) begin
              list[k] = '{cmd: CMD_CURSOR, row: crow, col: ccol, default: '0};
              k++;
            end
          end
          "Q": insert_mode_nxt = 1'b1;
          "R": insert_mode_nxt = 1'b0;
          "h": begin
            cursor_row_nxt = 7'd0;
            cursor_col_nxt = 8'd0;
            if (cfg.cursor_visible) begin
              list[k] = '{cmd: CMD_MOVE, default: '0};
              k++;
            end
          end
          "D": begin
            if (ccol > 8'd0) begin
              cursor_col_nxt = ccol - 8'd1;
              if (cfg.cursor_visible) begin
                list[k] = '{cmd: CMD_MOVE, row: crow, col: cursor_col_nxt, default: '0};
                k++;
              end
            end
          end
          default: ;
        endcase
      end
    end

    if (plain) begin
      case (pc)
        8'h0A: begin
          down_req = 1'b1;
          dl_inv   = 1'b1;
        end
        8'h0D: begin
          if (ccol != 8'd0) begin
            cursor_col_nxt = 8'd0;
            if (cfg.cursor_visible) begin
              list[k] = '{cmd: CMD_MOVE, row: crow, col: 8'd0, default: '0};
              k++;
            end
          end
        end
        8'h08: begin
          if (ccol != 8'd0) begin
            cursor_col_nxt = ccol - 8'd1;
            if (cfg.cursor_visible) begin
              list[k] = '{cmd: CMD_MOVE, row: crow, col: cursor_col_nxt, default: '0};
              k++;
            end
          end
        end
        8'h09: begin
          if (ccol < cfg.tab_limit) begin
            tn = {1'b0, ccol} + 9'(TabSize) - 9'(ccol % 8'(TabSize));
            cursor_col_nxt = (tn < cm1) ? 8'(tn) : 8'(cm1);
            if (cfg.cursor_visible) begin
              list[k] = '{cmd: CMD_MOVE, row: crow, col: cursor_col_nxt, default: '0};
              k++;
            end
          end else wrap_req = 1'b1;
        end
        8'h07: begin
          if (cfg.bell_enabled) begin
            list[k] = '{cmd: CMD_BELL, default: '0};
            k++;
          end
        end
        K_ESC: escape_char_nxt = K_ESC;
        default: begin
          if (pc >= 8'h20 && pc != 8'h7F) begin
            if (insert_mode_r) begin
              if ({1'b0, ccol} < cm1) begin
                if (cfg.cursor_visible) begin
                  list[k] = '{cmd: CMD_ERASE, row: crow, col: ccol, default: '0};
                  k++;
                end
                list[k] = '{cmd: CMD_SCROLL, row: crow, col: ccol, row_span: 8'd1,
                            col_span: cm1 - {1'b0, ccol}, scroll_dir: DIR_RIGHT,
                            default: '0};
                k++;
              end
              list[k] = '{cmd: CMD_DRAW, row: crow, col: ccol, glyph: 7'h20, default: '0};
              k++;
              if (cfg.cursor_visible) begin
                list[k] = '{cmd: CMD_CURSOR, row: crow, col: ccol, default: '0};
                k++;
              end
            end
            list[k] = '{cmd: CMD_DRAW, row: crow, col: ccol, glyph: pc[6:0],
                        inverse: attr_bits_r[0], default: '0};
            k++;
            if (cfg.cursor_visible) begin
              list[k] = '{cmd: CMD_CURSOR, row: crow, col: ccol, default: '0};
              k++;
            end
            wrap_req = 1'b1;
          end
        end
      endcase
    end

    if (wrap_req) begin
      if ({1'b0, cursor_col_nxt} + 9'd1 >= ncols) begin
        cursor_col_nxt   = 8'd0;
        attr_bits_nxt[0] = 1'b0;
        down_req         = 1'b1;
      end else begin
        cursor_col_nxt = cursor_col_nxt + 8'd1;
        if (cfg.cursor_visible) begin
          list[k] = '{cmd: CMD_MOVE, row: cursor_row_nxt, col: cursor_col_nxt,
                      default: '0};
          k++;
        end
      end
    end

    if (down_req) begin
      if ({1'b0, cursor_row_nxt} + 8'd1 >= nrows) begin
        cursor_row_nxt = 7'(rm1);
        if (cfg.cursor_visible) begin
          list[k] = '{cmd: CMD_ERASE, row: cursor_row_nxt, col: cursor_col_nxt, default: '0};
          k++;
        end
        list[k] = '{cmd: CMD_SCROLL, row: 7'd1, col: 8'd0, row_span: rm1, col_span: ncols,
                    scroll_dir: DIR_UP, default: '0};
        k++;
        list[k] = '{cmd: CMD_CLEAR, row: cursor_row_nxt, col: 8'd0, row_span: 8'd1,
                    col_span: ncols, default: '0};
        k++;
        if (cfg.cursor_visible) begin
          list[k] = '{cmd: CMD_CURSOR, row: cursor_row_nxt, col: cursor_col_nxt,
                      default: '0};
          k++;
        end
      end else begin
        cursor_row_nxt = cursor_row_nxt + 7'd1;
        if (cfg.cursor_visible) begin
          list[k] = '{cmd: CMD_MOVE, row: cursor_row_nxt, col: cursor_col_nxt,
                      default: '0};
          k++;
        end
      end
      if (dl_inv) attr_bits_nxt[0] = 1'b0;
    end
    nres = 4'(k);
  end

  // Mode flags are captured at each emit point; they only change at the byte's end
  // except for attribute clears that follow the emits, so use the entry state.
  res_t cur_word;
  always_comb begin
    cur_word = list[step_r];
    cur_word.mode_flags = {insert_mode_r, attr_bits_r[2:1]};
    cur_word.last = (step_r + 4'd1 == nres);
  end

  logic emit_now, finish;
  assign emit_now  = busy_r && !res_stall && (step_r < nres);
  assign finish    = busy_r && !res_stall && (step_r + 4'd1 >= nres);
  assign in_full   = busy_r && !finish;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (finish) begin
      busy_nxt = 1'b0;
      step_nxt = 4'd0;
    end else if (emit_now) step_nxt = step_r + 4'd1;
    if (in_push && !in_full) busy_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      step_r        <= '0;
      cursor_col_r  <= '0;
      cursor_row_r  <= '0;
      escape_char_r <= '0;
      digit_count_r <= '0;
      addr_accum_r  <= '0;
      held_char_r   <= '0;
      attr_bits_r   <= '0;
      insert_mode_r <= 1'b0;
      pend_r        <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      pend_r <= emit_now;
      if (finish) begin
        cursor_col_r  <= cursor_col_nxt;
        cursor_row_r  <= cursor_row_nxt;
        escape_char_r <= escape_char_nxt;
        digit_count_r <= digit_count_nxt;
        addr_accum_r  <= addr_accum_nxt;
        held_char_r   <= held_char_nxt;
        attr_bits_r   <= attr_bits_nxt;
        insert_mode_r <= insert_mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_push && !in_full) byte_r <= in_data;
    if (emit_now) pend_data_r <= cur_word;
  end

  assign res_valid = pend_r;
  assign res_data  = pend_data_r;
endmodule
`default_nettype wire

// ===== src/tec_checker.sv =====
`default_nettype none
module tec_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_push,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [2:0] out_cmd,
  input wire logic [7:0] out_row_span,
  input wire logic       cfg_ready
);
  import tec_pkg::*;

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_cmd != 3'd7) else $error("bad command code");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty) else $error("queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty) else $error("word dropped");

  a_bell_span: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_cmd == CMD_BELL) |-> out_row_span == 8'd0)
    else $error("bell with span");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port stalled");
endmodule

bind terminal_escape_cursor_engine_unit tec_checker u_tec_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_push      (in_push),
  .in_full      (in_full),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_cmd      (out_cmd),
  .out_row_span (out_row_span),
  .cfg_ready    (cfg_ready)
);
`default_nettype wire

// ===== tb/sv/terminal_escape_cursor_engine_unit_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module terminal_escape_cursor_engine_unit_tb;
  import tec_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_byte = 8'h00;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [2:0] out_cmd;
  logic [6:0] out_row;
  logic [7:0] out_col;
  logic [7:0] out_row_span;
  logic [8:0] out_col_span;
  logic [6:0] out_glyph;
  logic       out_inverse;
  logic [1:0] out_scroll_dir;
  logic [2:0] out_mode_flags;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic [8:0] cfg_data = 9'd0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  terminal_escape_cursor_engine_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_byte(in_byte),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_cmd(out_cmd), .out_row(out_row), .out_col(out_col),
    .out_row_span(out_row_span), .out_col_span(out_col_span),
    .out_glyph(out_glyph), .out_inverse(out_inverse),
    .out_scroll_dir(out_scroll_dir), .out_mode_flags(out_mode_flags),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Display model state.
  int unsigned rows_reg, cols_reg, tab_reg, cursor_on, bell_on;
  int unsigned cur_col, cur_row, esc_char, digit_cnt, addr_acc, held, attrs, ins_mode;
  int unsigned byte_words;
  res_t expected_words[$];

  int errors = 0;
  int words_checked = 0;
  int bytes_sent = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  function automatic int unsigned n_rows();
    return rows_reg < 1 ? 1 : (rows_reg > MaxRows ? MaxRows : rows_reg);
  endfunction

  function automatic int unsigned n_cols();
    return cols_reg < 1 ? 1 : (cols_reg > MaxCols ? MaxCols : cols_reg);
  endfunction

  function automatic void push_word(int unsigned cmd, int unsigned row, int unsigned col,
                                    int unsigned rs, int unsigned cs, int unsigned glyph,
                                    int unsigned inv, int unsigned dir);
    res_t w;
    if (byte_words >= 12) return;
    w.cmd        = cmd[2:0];
    w.row        = row[6:0];
    w.col        = col[7:0];
    w.row_span   = rs[7:0];
    w.col_span   = cs[8:0];
    w.glyph      = glyph[6:0];
    w.inverse    = inv[0];
    w.scroll_dir = dir[1:0];
    w.mode_flags = {ins_mode[0], attrs[2:1]};
    w.last       = 1'b0;
    expected_words.push_back(w);
    byte_words++;
  endfunction

  function automatic void cursor_word(cmd_t cmd);
    if (cursor_on[0]) push_word(cmd, cur_row, cur_col, 0, 0, 0, 0, 0);
  endfunction

  function automatic void clear_line(int unsigned y, int unsigned x);
    push_word(CMD_CLEAR, y, x, 1, n_cols() - x, 0, 0, 0);
    cursor_word(CMD_CURSOR);
  endfunction

  function automatic void line_down();
    if (cur_row + 1 >= n_rows()) begin
      cur_row = n_rows() - 1;
      cursor_word(CMD_ERASE);
      push_word(CMD_SCROLL, 1, 0, n_rows() - 1, n_cols(), 0, 0, DIR_UP);
      clear_line(cur_row, 0);
    end else begin
      cur_row++;
      cursor_word(CMD_MOVE);
    end
  endfunction

  function automatic void advance_col();
    if (cur_col + 1 >= n_cols()) begin
      cur_col = 0;
      attrs &= ~32'd1;
      line_down();
    end else begin
      cur_col++;
      cursor_word(CMD_MOVE);
    end
  endfunction

  function automatic void edit_chars(bit insert);
    if (cur_col < n_cols() - 1) begin
      cursor_word(CMD_ERASE);
      if (insert)
        push_word(CMD_SCROLL, cur_row, cur_col, 1, n_cols() - cur_col - 1, 0, 0, DIR_RIGHT);
      else
        push_word(CMD_SCROLL, cur_row, cur_col + 1, 1, n_cols() - cur_col - 1, 0, 0, DIR_LEFT);
    end
    push_word(CMD_DRAW, cur_row, insert ? cur_col : n_cols() - 1, 0, 0, 8'h20, 0, 0);
    cursor_word(CMD_CURSOR);
  endfunction

  function automatic void edit_lines(bit insert);
    if (cur_row < n_rows() - 1) begin
      cursor_word(CMD_ERASE);
      if (insert)
        push_word(CMD_SCROLL, cur_row, 0, n_rows() - cur_row - 1, n_cols(), 0, 0, DIR_DOWN);
      else
        push_word(CMD_SCROLL, cur_row + 1, 0, n_rows() - cur_row - 1, n_cols(), 0, 0, DIR_UP);
    end
    clear_line(insert ? cur_row : n_rows() - 1, 0);
  endfunction

  // Returns 1 when the byte also goes through ordinary character handling.
  function automatic bit escape_step(int unsigned c);
    int unsigned e;
    int unsigned m;
    e = esc_char;
    if (e == K_ESC) begin
      esc_char = c;
      if (c == K_ESC) return 1'b1;
      digit_cnt = 0;
      e = c;
    end
    case (e)
      "&": begin
        if (digit_cnt != 0) begin
          esc_char = c;
          digit_cnt = 0;
        end else digit_cnt = 1;
        return 1'b0;
      end
      "a": begin
        if (c == "Y" || c == "y") begin
          m = n_rows() - 1;
          cur_row = addr_acc < m ? addr_acc : m;
          addr_acc = 0;
          if (c == "y") begin
            digit_cnt = 0;
            return 1'b0;
          end
          esc_char = 0;
          cursor_word(CMD_MOVE);
          attrs &= ~32'd1;
        end else if (c == "C") begin
          m = n_cols() - 1;
          cur_col = addr_acc < m ? addr_acc : m;
          addr_acc = 0;
          esc_char = 0;
          cursor_word(CMD_MOVE);
          attrs &= ~32'd1;
        end else if (c >= "0" && c <= "9" && digit_cnt < 3) begin
          addr_acc = (addr_acc * 10 + (c - "0")) & 32'h3FF;
          digit_cnt++;
        end else begin
          addr_acc = 0;
          esc_char = 0;
        end
        return 1'b0;
      end
      "d": begin
        if (c == "B") attrs |= 1;
        else if (c == "D") attrs |= 2;
        else if (c == "@") attrs &= ~32'd3;
        esc_char = 0;
        return 1'b0;
      end
      "s": begin
        if (digit_cnt == 0) begin
          held = c;
          digit_cnt = 1;
          return 1'b0;
        end
        if (digit_cnt == 1) begin
          if (c == "A") begin
            if (held == "0") attrs &= ~32'd4;
            else if (held == "1") attrs |= 4;
          end
          held = 0;
        end
        esc_char = 0;
        return 1'b0;
      end
      "i": begin
        cur_col = cur_col > TabSize ? cur_col % TabSize : 0;
        cursor_word(CMD_MOVE);
      end
      "K": clear_line(cur_row, cur_col);
      "J": begin
        push_word(CMD_CLEAR, cur_row, 0, n_rows() - cur_row, n_cols(), 0, 0, 0);
        cursor_word(CMD_CURSOR);
      end
      "B": begin
        line_down();
        attrs &= ~32'd1;
      end
      "C": begin
        esc_char = 0;
        advance_col();
        return 1'b0;
      end
      "A": begin
        if (cur_row > 0) begin
          cur_row--;
          cursor_word(CMD_MOVE);
        end
        attrs &= ~32'd1;
      end
      "P": edit_chars(1'b0);
      "M": edit_lines(1'b0);
      "Q": ins_mode = 1;
      "R": ins_mode = 0;
      "L": edit_lines(1'b1);
      "h": begin
        cur_row = 0;
        cur_col = 0;
        cursor_word(CMD_MOVE);
      end
      "D": begin
        if (cur_col > 0) begin
          cur_col--;
          cursor_word(CMD_MOVE);
        end
      end
      default: ;
    endcase
    esc_char = 0;
    return 1'b0;
  endfunction

  function automatic void char_step(int unsigned raw);
    int unsigned c;
    int unsigned m;
    int unsigned n;
    c = raw & 32'h7F;
    case (c)
      8'h0A: begin
        line_down();
        attrs &= ~32'd1;
      end
      8'h0D: begin
        if (cur_col != 0) begin
          cur_col = 0;
          cursor_word(CMD_MOVE);
        end
      end
      8'h08: begin
        if (cur_col != 0) begin
          cur_col--;
          cursor_word(CMD_MOVE);
        end
      end
      8'h09: begin
        if (cur_col < tab_reg) begin
          m = n_cols() - 1;
          n = cur_col + TabSize - cur_col % TabSize;
          cur_col = n < m ? n : m;
          cursor_word(CMD_MOVE);
        end else advance_col();
      end
      8'h07: if (bell_on[0]) push_word(CMD_BELL, 0, 0, 0, 0, 0, 0, 0);
      K_ESC: esc_char = K_ESC;
      default: begin
        if (c >= 8'h20 && c != 8'h7F) begin
          if (ins_mode != 0) edit_chars(1'b1);
          push_word(CMD_DRAW, cur_row, cur_col, 0, 0, c, attrs & 1, 0);
          cursor_word(CMD_CURSOR);
          advance_col();
        end
      end
    endcase
  endfunction

  function automatic int unsigned predict_byte(logic [7:0] b);
    byte_words = 0;
    if (cur_row > n_rows() - 1) cur_row = n_rows() - 1;
    if (cur_col > n_cols() - 1) cur_col = n_cols() - 1;
    if (esc_char == 0 || escape_step(b)) char_step(b);
    if (byte_words > 0) expected_words[$].last = 1'b1;
    return byte_words;
  endfunction

  function automatic res_t word_of(cmd_t cmd, int unsigned row, int unsigned col,
                                   int unsigned glyph, bit last);
    res_t w;
    w = '0;
    w.cmd   = cmd;
    w.row   = row[6:0];
    w.col   = col[7:0];
    w.glyph = glyph[6:0];
    w.last  = last;
    return w;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic check_word();
    res_t got;
    res_t want;
    got = {out_cmd, out_row, out_col, out_row_span, out_col_span, out_glyph,
           out_inverse, out_scroll_dir, out_mode_flags, out_last};
    words_checked++;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word %h", got));
      return;
    end
    want = expected_words.pop_front();
    if (got.cmd != want.cmd) report_mismatch($sformatf("cmd %0d want %0d", got.cmd, want.cmd));
    if (got.row != want.row) report_mismatch($sformatf("row %0d want %0d", got.row, want.row));
    if (got.col != want.col) report_mismatch($sformatf("col %0d want %0d", got.col, want.col));
    if (got.row_span != want.row_span)
      report_mismatch($sformatf("row_span %0d want %0d", got.row_span, want.row_span));
    if (got.col_span != want.col_span)
      report_mismatch($sformatf("col_span %0d want %0d", got.col_span, want.col_span));
    if (got.glyph != want.glyph)
      report_mismatch($sformatf("glyph %h want %h", got.glyph, want.glyph));
    if (got.inverse != want.inverse)
      report_mismatch($sformatf("inverse %0d want %0d", got.inverse, want.inverse));
    if (got.scroll_dir != want.scroll_dir)
      report_mismatch($sformatf("scroll_dir %0d want %0d", got.scroll_dir, want.scroll_dir));
    if (got.mode_flags != want.mode_flags)
      report_mismatch($sformatf("mode_flags %0d want %0d", got.mode_flags, want.mode_flags));
    if (got.last != want.last)
      report_mismatch($sformatf("last %0d want %0d", got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_word();
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, output int unsigned n);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_full);
    n = predict_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[8:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROWS:   rows_reg  = value & 32'hFF;
      REG_COLS:   cols_reg  = value & 32'h1FF;
      REG_TAB:    tab_reg   = value & 32'hFF;
      REG_CURSOR: cursor_on = value & 1;
      REG_BELL:   bell_on   = value & 1;
      default: ;
    endcase
  endtask

  task automatic add_digits(ref logic [7:0] q[$], input int unsigned cnt);
    repeat (cnt) q.push_back(8'h30 + $urandom_range(9));
  endtask

  // Builds one random byte sequence, mostly well-formed escapes.
  task automatic random_sequence(ref logic [7:0] q[$]);
    logic [7:0] letters[13] = '{"i", "K", "J", "B", "C", "A", "P", "M", "Q", "R", "L", "h", "D"};
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 30) begin
      q.push_back($urandom_range(8'h7E, 8'h20) | ($urandom_range(1) << 7));
    end else if (kind < 42) begin
      case ($urandom_range(4))
        0: q.push_back(8'h07);
        1: q.push_back(8'h08);
        2: q.push_back(8'h09);
        3: q.push_back(8'h0A);
        default: q.push_back(8'h0D);
      endcase
    end else if (kind < 47) begin
      q.push_back($urandom_range(255));
    end else if (kind < 67) begin
      q.push_back(K_ESC);
      q.push_back($urandom_range(9) == 0 ? $urandom_range(255) : letters[$urandom_range(12)]);
    end else if (kind < 85) begin
      q.push_back(K_ESC);
      q.push_back("&");
      q.push_back("a");
      if ($urandom_range(1)) begin
        add_digits(q, $urandom_range(3, 1));
        q.push_back("y");
      end
      add_digits(q, $urandom_range(9) == 0 ? 4 : $urandom_range(3, 1));
      case ($urandom_range(5))
        0: q.push_back($urandom_range(255));
        1, 2: q.push_back("C");
        default: q.push_back("Y");
      endcase
    end else if (kind < 93) begin
      q.push_back(K_ESC);
      q.push_back("&");
      q.push_back("d");
      case ($urandom_range(3))
        0: q.push_back("B");
        1: q.push_back("D");
        2: q.push_back("@");
        default: q.push_back($urandom_range(255));
      endcase
    end else begin
      q.push_back(K_ESC);
      q.push_back("&");
      q.push_back("s");
      q.push_back($urandom_range(3) == 0 ? $urandom_range(255) : "0" + $urandom_range(1));
      q.push_back($urandom_range(3) == 0 ? $urandom_range(255) : "A");
    end
  endtask

  typedef struct {
    logic [7:0] b;
    bit         has_exp;
    res_t       exp;
  } step_row_t;

  initial begin
    step_row_t rows[$];
    logic [7:0] seq[$];
    int unsigned n;
    int phase;

    rows_reg = 24; cols_reg = 80; tab_reg = 72; cursor_on = 1; bell_on = 1;
    cur_col = 0; cur_row = 0; esc_char = 0; digit_cnt = 0;
    addr_acc = 0; held = 0; attrs = 0; ins_mode = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back('{8'h07, 1'b1, word_of(CMD_BELL, 0, 0, 0, 1'b1)});
    rows.push_back('{"A", 1'b1, word_of(CMD_DRAW, 0, 0, 8'h41, 1'b0)});
    rows.push_back('{8'hC1, 1'b1, word_of(CMD_DRAW, 0, 1, 8'h41, 1'b0)});
    rows.push_back('{8'hFF, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, '0});
    foreach (u8_str_a[i]) rows.push_back('{u8_str_a[i], 1'b0, '0});
    rows.push_back('{"Y", 1'b1, word_of(CMD_MOVE, 23, 2, 0, 1'b1)});
    foreach (u8_str_b[i]) rows.push_back('{u8_str_b[i], 1'b0, '0});

    foreach (rows[i]) begin
      send_byte(rows[i].b, n);
      if (rows[i].has_exp) begin
        if (n == 0) report_mismatch($sformatf("no word predicted for byte %h", rows[i].b));
        else if (expected_words[expected_words.size() - n] != rows[i].exp)
          report_mismatch($sformatf("first word of byte %h disagrees with table", rows[i].b));
      end
    end
    wait_idle();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_ROWS, 5); write_reg(REG_COLS, 12); write_reg(REG_TAB, 8);
          sender_idle_pct = 0; stall_pct = 0;
        end
        1: begin
          write_reg(REG_ROWS, 1); write_reg(REG_COLS, 1); write_reg(REG_TAB, 0);
          write_reg(REG_BELL, 0);
          sender_idle_pct = 67; stall_pct = 0;
        end
        2: begin
          write_reg(REG_ROWS, 128); write_reg(REG_COLS, 256); write_reg(REG_TAB, 255);
          write_reg(REG_BELL, 1);
          sender_idle_pct = 0; stall_pct = 67;
          hold_cycles = 300;
        end
        3: begin
          write_reg(REG_ROWS, 255); write_reg(REG_COLS, 511); write_reg(REG_CURSOR, 0);
          sender_idle_pct = 31; stall_pct = 31;
        end
        4: begin
          write_reg(REG_ROWS, 0); write_reg(REG_COLS, 0); write_reg(REG_CURSOR, 1);
          sender_idle_pct = 67; stall_pct = 67;
        end
        5: begin
          write_reg(REG_ROWS, 3); write_reg(REG_COLS, 20); write_reg(REG_TAB, 17);
          sender_idle_pct = 0; stall_pct = 0;
        end
        6: begin
          write_reg(REG_ROWS, 2); write_reg(REG_COLS, 9);
          sender_idle_pct = 31; stall_pct = 31;
        end
        default: begin
          write_reg(REG_ROWS, 24); write_reg(REG_COLS, 80); write_reg(REG_TAB, 72);
          sender_idle_pct = 0; stall_pct = 0;
          hold_cycles = 200;
        end
      endcase
      seq.delete();
      while (seq.size() < 30) random_sequence(seq);
      foreach (seq[i]) send_byte(seq[i], n);
      wait_idle();
    end

    $display("Sent %0d bytes over %0d settings, checked %0d command words.",
             bytes_sent, 9, words_checked);
    $display("Covered cursor, escape, attribute, keypad and edit sequences with stalls.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Escape sequences, control bytes and characters used in the directed table.
  logic [7:0] u8_str_a[6] = '{K_ESC, "&", "a", "5", "0", "0"};
  logic [7:0] u8_str_b[16] = '{8'h09, 8'h08, 8'h0D, 8'h0A, K_ESC, "J", K_ESC, "&", "d", "B",
                               "x", K_ESC, "Q", "z", K_ESC, "i"};

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
